// ===== src/motor_current_fire_stall_detector_unit_defines.svh =====
// Assertion macros used by the port-level checker file.
`ifndef MOTOR_CURRENT_FIRE_STALL_DETECTOR_UNIT_DEFINES_SVH
`define MOTOR_CURRENT_FIRE_STALL_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define MCFSD_ASSERT_IMP(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mcfsd check failed");

// Next-cycle implication, off while reset is high.
`define MCFSD_ASSERT_NXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mcfsd check failed");

`endif

// ===== src/mcfsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfsd_pkg
// Shared types and constants of the fire and stall detector.
// ----------------------------------------------------------------------------
package mcfsd_pkg;

  localparam int TIME_WIDTH_DEF   = 32;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Timing thresholds are fixed 16-bit millisecond counts.
  localparam int THR_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;

  // Reset values of the configuration registers.
  localparam int IDLE_OFFSET_RST   = 0;
  localparam int TRIGGER_LEVEL_RST = 800;
  localparam logic [THR_WIDTH-1:0] DEBOUNCE_RST      = 16'd20;
  localparam logic [THR_WIDTH-1:0] PULSE_GAP_RST     = 16'd30;
  localparam logic [THR_WIDTH-1:0] STALL_RST         = 16'd2000;
  localparam logic [THR_WIDTH-1:0] END_RST           = 16'd150;
  localparam logic [THR_WIDTH-1:0] STALL_RELEASE_RST = 16'd5000;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_FIRING = 2'd1,
    MODE_STALL  = 2'd2
  } mode_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_IDLE_OFFSET        = 3'd0,
    REG_TRIGGER_LEVEL      = 3'd1,
    REG_DEBOUNCE_TIME      = 3'd2,
    REG_PULSE_GAP_TIME     = 3'd3,
    REG_STALL_TIME         = 3'd4,
    REG_END_TIME           = 3'd5,
    REG_STALL_RELEASE_TIME = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [THR_WIDTH-1:0] debounce_time;
    logic [THR_WIDTH-1:0] pulse_gap_time;
    logic [THR_WIDTH-1:0] stall_time;
    logic [THR_WIDTH-1:0] end_time;
    logic [THR_WIDTH-1:0] stall_release_time;
  } cfg_times_t;

  typedef struct packed {
    logic  fire_pulse;
    logic  stall_event;
    logic  fire_end;
    mode_t mode_now;
  } result_t;

endpackage

// ===== src/mcfsd_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfsd_sample_if
// Input channel: one timestamped shunt sample per item.
// ----------------------------------------------------------------------------
interface mcfsd_sample_if
  import mcfsd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int TIME_WIDTH   = TIME_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] shunt_sample;
  logic        [TIME_WIDTH-1:0]   now_ms;

  modport source (output valid, output shunt_sample, output now_ms, input ready);
  modport sink   (input valid, input shunt_sample, input now_ms, output ready);
endinterface

// ===== src/mcfsd_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfsd_result_if
// Output channel: event flags and mode after each sample.
// ----------------------------------------------------------------------------
interface mcfsd_result_if;
  logic       valid;
  logic       ready;
  logic       fire_pulse;
  logic       stall_event;
  logic       fire_end;
  logic [1:0] mode_now;

  modport source (output valid, output fire_pulse, output stall_event, output fire_end,
                  output mode_now, input ready);
  modport sink   (input valid, input fire_pulse, input stall_event, input fire_end,
                  input mode_now, output ready);
endinterface

// ===== src/mcfsd_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfsd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mcfsd_cfg_if
  import mcfsd_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/motor_current_fire_stall_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_current_fire_stall_detector_unit
// Shunt-current fire/stall detector with registered input and result stages.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one item = shunt_sample (signed raw reading) + now_ms timestamp.
//   result : one item per sample = fire_pulse, stall_event, fire_end flags and
//            mode_now (0 idle, 1 firing, 2 stall) after that sample.
//   cfg    : register writes (index 0..6), always ready; write only while the
//            block is idle. Index 7 is ignored.
// Path: input register, then result register. Throughput: one item per
//   cycle while result is not held off. The input register feeds a single
//   step of subtract/compare logic and the mode registers in the same cycle,
//   so the mode/run state is current for the next sample right away.
// Stall: when result is held off, the result register keeps its item, one
//   more sample can wait in the input register, then sample.ready drops.
// Reset (rst, synchronous): both stages empty, mode idle, no open runs,
//   configuration back to its defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module motor_current_fire_stall_detector_unit
  import mcfsd_pkg::*;
#(
  parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  mcfsd_sample_if.sink   sample,
  mcfsd_result_if.source result,
  mcfsd_cfg_if.sink      cfg
);

  // Input stage
  logic                           in_full;
  logic signed [SAMPLE_WIDTH-1:0] shunt_q;
  logic        [TIME_WIDTH-1:0]   now_q;

  // Result stage
  logic    out_full;
  result_t res_q;
  result_t step_res;

  // Configuration
  logic signed [SAMPLE_WIDTH-1:0] idle_offset;
  logic signed [SAMPLE_WIDTH-1:0] trigger_level;
  cfg_times_t                     times;

  logic advance;
  logic take;

  // The held sample moves on whenever the result register is free or
  // being emptied in this cycle; state updates on the same edge.
  assign advance      = in_full && (!out_full || result.ready);
  assign sample.ready = !in_full || advance;
  assign take         = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (take) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_full <= 1'b1;
      end else if (result.ready) begin
        out_full <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      shunt_q <= sample.shunt_sample;
      now_q   <= sample.now_ms;
    end
    if (advance) begin
      res_q <= step_res;
    end
  end

  mcfsd_cfg_regs #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .idle_offset   (idle_offset),
    .trigger_level (trigger_level),
    .times         (times)
  );

  mcfsd_step #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_step (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .shunt_sample  (shunt_q),
    .now_ms        (now_q),
    .idle_offset   (idle_offset),
    .trigger_level (trigger_level),
    .times         (times),
    .res           (step_res)
  );

  assign result.valid       = out_full;
  assign result.fire_pulse  = res_q.fire_pulse;
  assign result.stall_event = res_q.stall_event;
  assign result.fire_end    = res_q.fire_end;
  assign result.mode_now    = res_q.mode_now;

endmodule

// ===== src/mcfsd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfsd_cfg_regs
// Configuration register file; writes are always taken.
// ----------------------------------------------------------------------------
module mcfsd_cfg_regs
  import mcfsd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  mcfsd_cfg_if.sink                      cfg,
  output logic signed [SAMPLE_WIDTH-1:0] idle_offset,
  output logic signed [SAMPLE_WIDTH-1:0] trigger_level,
  output cfg_times_t                     times
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_offset                    <= SAMPLE_WIDTH'(IDLE_OFFSET_RST);
      trigger_level                  <= SAMPLE_WIDTH'(TRIGGER_LEVEL_RST);
      times.debounce_time            <= DEBOUNCE_RST;
      times.pulse_gap_time           <= PULSE_GAP_RST;
      times.stall_time               <= STALL_RST;
      times.end_time                 <= END_RST;
      times.stall_release_time       <= STALL_RELEASE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_IDLE_OFFSET:        idle_offset   <= cfg.data[SAMPLE_WIDTH-1:0];
        REG_TRIGGER_LEVEL:      trigger_level <= cfg.data[SAMPLE_WIDTH-1:0];
        REG_DEBOUNCE_TIME:      times.debounce_time      <= cfg.data[THR_WIDTH-1:0];
        REG_PULSE_GAP_TIME:     times.pulse_gap_time     <= cfg.data[THR_WIDTH-1:0];
        REG_STALL_TIME:         times.stall_time         <= cfg.data[THR_WIDTH-1:0];
        REG_END_TIME:           times.end_time           <= cfg.data[THR_WIDTH-1:0];
        REG_STALL_RELEASE_TIME: times.stall_release_time <= cfg.data[THR_WIDTH-1:0];
        default: ; // unused index: write dropped
      endcase
    end
  end

endmodule

// ===== src/mcfsd_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfsd_step
// Mode machine: run/pulse timestamps and the per-sample update.
// ----------------------------------------------------------------------------
module mcfsd_step
  import mcfsd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int TIME_WIDTH   = TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic signed [SAMPLE_WIDTH-1:0] shunt_sample,
  input  logic        [TIME_WIDTH-1:0]   now_ms,
  input  logic signed [SAMPLE_WIDTH-1:0] idle_offset,
  input  logic signed [SAMPLE_WIDTH-1:0] trigger_level,
  input  cfg_times_t                     times,
  output result_t                        res
);

  mode_t                 mode, mode_next;
  logic [TIME_WIDTH-1:0] high_run_start, high_run_start_next;
  logic                  high_run_valid, high_run_valid_next;
  logic [TIME_WIDTH-1:0] low_run_start, low_run_start_next;
  logic                  low_run_valid, low_run_valid_next;
  logic [TIME_WIDTH-1:0] last_pulse_time, last_pulse_time_next;

  logic signed [SAMPLE_WIDTH:0] corrected;
  logic                         high;
  logic [TIME_WIDTH-1:0]        el_high, el_low, el_pulse;

  // Exact difference, one extra bit, no saturation.
  assign corrected = {shunt_sample[SAMPLE_WIDTH-1], shunt_sample}
                   - {idle_offset[SAMPLE_WIDTH-1], idle_offset};
  assign high = corrected > $signed({trigger_level[SAMPLE_WIDTH-1], trigger_level});

  // Elapsed since last pulse wraps at the timestamp width.
  assign el_pulse = now_ms - last_pulse_time;

  always_comb begin
    mode_next            = mode;
    high_run_start_next  = high_run_start;
    high_run_valid_next  = high_run_valid;
    low_run_start_next   = low_run_start;
    low_run_valid_next   = low_run_valid;
    last_pulse_time_next = last_pulse_time;
    res                  = '0;

    // Run starts are opened first; elapsed times use the opened value.
    unique case (mode)
      MODE_FIRING: begin
        if (high) begin
          if (low_run_valid || !high_run_valid) begin
            high_run_start_next = now_ms;
            high_run_valid_next = 1'b1;
          end
        end else if (!low_run_valid) begin
          low_run_start_next = now_ms;
          low_run_valid_next = 1'b1;
        end
      end
      MODE_STALL: ;
      default: begin
        if (high && !high_run_valid) begin
          high_run_start_next = now_ms;
          high_run_valid_next = 1'b1;
        end
      end
    endcase

    // Run lengths wrap at the timestamp width, taken from the starts above.
    el_high = now_ms - high_run_start_next;
    el_low  = now_ms - low_run_start_next;

    unique case (mode)
      MODE_FIRING: begin
        if (high) begin
          if (low_run_valid && el_low >= TIME_WIDTH'(times.pulse_gap_time)
              && el_pulse >= TIME_WIDTH'(times.pulse_gap_time)) begin
            last_pulse_time_next = now_ms;
            res.fire_pulse       = 1'b1;
          end
          low_run_valid_next = 1'b0;
          if (el_high >= TIME_WIDTH'(times.stall_time)) begin
            mode_next       = MODE_STALL;
            res.stall_event = 1'b1;
          end
        end else if (el_low >= TIME_WIDTH'(times.end_time)) begin
          mode_next           = MODE_IDLE;
          high_run_valid_next = 1'b0;
          low_run_valid_next  = 1'b0;
          res.fire_end        = 1'b1;
        end
      end
      MODE_STALL: begin
        if (!high || el_high >= TIME_WIDTH'(times.stall_release_time)) begin
          mode_next           = MODE_IDLE;
          high_run_valid_next = 1'b0;
          low_run_valid_next  = 1'b0;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
        if (high) begin
          if (el_high >= TIME_WIDTH'(times.debounce_time)) begin
            mode_next            = MODE_FIRING;
            high_run_start_next  = now_ms;
            low_run_valid_next   = 1'b0;
            last_pulse_time_next = now_ms;
            res.fire_pulse       = 1'b1;
          end
        end else begin
          high_run_valid_next = 1'b0;
        end
      end
    endcase

    res.mode_now = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      high_run_start  <= '0;
      high_run_valid  <= 1'b0;
      low_run_start   <= '0;
      low_run_valid   <= 1'b0;
      last_pulse_time <= '0;
    end else if (en) begin
      mode            <= mode_next;
      high_run_start  <= high_run_start_next;
      high_run_valid  <= high_run_valid_next;
      low_run_start   <= low_run_start_next;
      low_run_valid   <= low_run_valid_next;
      last_pulse_time <= last_pulse_time_next;
    end
  end

endmodule

// ===== src/mcfsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfsd_checker
// Port-level checks of the detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "motor_current_fire_stall_detector_unit_defines.svh"

module mcfsd_sva
  import mcfsd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       fire_pulse,
  input logic       stall_event,
  input logic       fire_end,
  input logic [1:0] mode_now
);

  // Input only backs up when the result side is full and stalled.
  `MCFSD_ASSERT_IMP(a_backpressure, clk, rst, !in_ready, out_valid && !out_ready)

  // An accepted sample is followed by a valid result item.
  `MCFSD_ASSERT_IMP(a_latency, clk, rst, in_valid && in_ready, ##2 out_valid)

  // Events agree with the reported mode.
  `MCFSD_ASSERT_IMP(a_event_mode, clk, rst, out_valid && (stall_event || fire_end),
    (stall_event && !fire_end && mode_now == MODE_STALL)
    || (fire_end && !stall_event && !fire_pulse && mode_now == MODE_IDLE))

  // A stalled result item holds.
  `MCFSD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(fire_pulse) && $stable(stall_event) && $stable(fire_end)
    && $stable(mode_now))

endmodule

bind motor_current_fire_stall_detector_unit mcfsd_sva u_mcfsd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .fire_pulse  (result.fire_pulse),
  .stall_event (result.stall_event),
  .fire_end    (result.fire_end),
  .mode_now    (result.mode_now)
);

// ===== test/mcfsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfsd_checker
// Watches the sample, result and register channels of the fire/stall
// detector, tracks its own copy of the mode machine and register file, and
// compares every result item against the oldest predicted one.
// ----------------------------------------------------------------------------
module mcfsd_checker
  import mcfsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  mcfsd_sample_if smp,
  mcfsd_result_if res,
  mcfsd_cfg_if    cfg,
  output int      errors,
  output int      pending
);

  // Register copy
  logic signed [SAMPLE_WIDTH_DEF-1:0] offset_q;
  logic signed [SAMPLE_WIDTH_DEF-1:0] trigger_q;
  logic [THR_WIDTH-1:0] debounce_q;
  logic [THR_WIDTH-1:0] gap_q;
  logic [THR_WIDTH-1:0] stall_q;
  logic [THR_WIDTH-1:0] end_q;
  logic [THR_WIDTH-1:0] release_q;

  // Mode machine copy
  mode_t                     mode_q;
  logic [TIME_WIDTH_DEF-1:0] hi_start;
  logic [TIME_WIDTH_DEF-1:0] lo_start;
  logic [TIME_WIDTH_DEF-1:0] pulse_at;
  logic                      hi_open;
  logic                      lo_open;

  result_t predicted_results[$];

  // Elapsed time, modulo the timestamp width.
  function automatic logic [TIME_WIDTH_DEF-1:0] span(input logic [TIME_WIDTH_DEF-1:0] now,
                                                      input logic [TIME_WIDTH_DEF-1:0] since);
    return now - since;
  endfunction

  // One sample through the mode machine; returns the flags and the new mode.
  function automatic result_t advance_detector(input logic signed [SAMPLE_WIDTH_DEF-1:0] shunt,
                                               input logic [TIME_WIDTH_DEF-1:0] now);
    result_t r;
    logic    hot;
    r   = '0;
    hot = (int'(shunt) - int'(offset_q)) > int'(trigger_q);
    case (mode_q)
      MODE_FIRING: begin
        if (hot) begin
          if (lo_open || !hi_open) begin
            hi_start = now;
            hi_open  = 1'b1;
          end
          if (lo_open && span(now, lo_start) >= gap_q && span(now, pulse_at) >= gap_q) begin
            pulse_at     = now;
            r.fire_pulse = 1'b1;
          end
          lo_open = 1'b0;
          if (span(now, hi_start) >= stall_q) begin
            mode_q        = MODE_STALL;
            r.stall_event = 1'b1;
          end
        end else begin
          if (!lo_open) begin
            lo_start = now;
            lo_open  = 1'b1;
          end
          if (span(now, lo_start) >= end_q) begin
            mode_q     = MODE_IDLE;
            hi_open    = 1'b0;
            lo_open    = 1'b0;
            r.fire_end = 1'b1;
          end
        end
      end
      MODE_STALL: begin
        if (!hot || span(now, hi_start) >= release_q) begin
          mode_q  = MODE_IDLE;
          hi_open = 1'b0;
          lo_open = 1'b0;
        end
      end
      default: begin
        mode_q = MODE_IDLE;
        if (hot) begin
          if (!hi_open) begin
            hi_start = now;
            hi_open  = 1'b1;
          end
          if (span(now, hi_start) >= debounce_q) begin
            mode_q       = MODE_FIRING;
            hi_start     = now;
            lo_open      = 1'b0;
            pulse_at     = now;
            r.fire_pulse = 1'b1;
          end
        end else begin
          hi_open = 1'b0;
        end
      end
    endcase
    r.mode_now = mode_q;
    return r;
  endfunction

  task automatic flag(input string what, input logic [1:0] want, input logic [1:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      offset_q   = SAMPLE_WIDTH_DEF'(IDLE_OFFSET_RST);
      trigger_q  = SAMPLE_WIDTH_DEF'(TRIGGER_LEVEL_RST);
      debounce_q = DEBOUNCE_RST;
      gap_q      = PULSE_GAP_RST;
      stall_q    = STALL_RST;
      end_q      = END_RST;
      release_q  = STALL_RELEASE_RST;
      mode_q     = MODE_IDLE;
      hi_start   = '0;
      lo_start   = '0;
      pulse_at   = '0;
      hi_open    = 1'b0;
      lo_open    = 1'b0;
      predicted_results.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result item with none expected, got mode %0d", $time, res.mode_now);
          errors++;
        end else begin
          want = predicted_results.pop_front();
          if (res.fire_pulse !== want.fire_pulse)
            flag("fire_pulse", want.fire_pulse, res.fire_pulse);
          if (res.stall_event !== want.stall_event)
            flag("stall_event", want.stall_event, res.stall_event);
          if (res.fire_end !== want.fire_end)
            flag("fire_end", want.fire_end, res.fire_end);
          if (res.mode_now !== want.mode_now)
            flag("mode_now", want.mode_now, res.mode_now);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_IDLE_OFFSET:        offset_q   = cfg.data[THR_WIDTH-1:0];
          REG_TRIGGER_LEVEL:      trigger_q  = cfg.data[THR_WIDTH-1:0];
          REG_DEBOUNCE_TIME:      debounce_q = cfg.data[THR_WIDTH-1:0];
          REG_PULSE_GAP_TIME:     gap_q      = cfg.data[THR_WIDTH-1:0];
          REG_STALL_TIME:         stall_q    = cfg.data[THR_WIDTH-1:0];
          REG_END_TIME:           end_q      = cfg.data[THR_WIDTH-1:0];
          REG_STALL_RELEASE_TIME: release_q  = cfg.data[THR_WIDTH-1:0];
          default: ;  // unmapped index, dropped
        endcase
      end
      if (smp.valid && smp.ready)
        predicted_results.push_back(advance_detector(smp.shunt_sample, smp.now_ms));
    end
    pending = predicted_results.size();
  end

endmodule

// ===== test/tb_motor_current_fire_stall_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_current_fire_stall_detector_unit
// Drives timestamped shunt samples and register writes into the detector.
// A short hand-written sequence walks every mode transition, then phases of
// random high/low runs run under several register settings and handshake
// loads. The checker beside the block scores every result item.
// ----------------------------------------------------------------------------
module tb_motor_current_fire_stall_detector_unit;
  import mcfsd_pkg::*;

  // Index 7 has no register behind it; writes there must be dropped.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = 3'd7;
  localparam int HOLD_CYCLES = 240;  // long result back-pressure stretch
  localparam int N_DIRECTED  = 23;

  logic clk = 1'b0;
  logic rst;

  mcfsd_sample_if smp ();
  mcfsd_result_if res ();
  mcfsd_cfg_if    cfg ();

  int errors;
  int pending;

  // Handshake load, percent of cycles each side sits idle.
  int src_gap_pct;
  int sink_gap_pct;

  // Flipped by the stimulus to ask the result side for one long hold-off.
  bit hold_req;
  bit hold_seen;

  // Running timestamp and the register values the stimulus believes are set,
  // used only to aim samples above or below the trigger.
  logic [TIME_WIDTH_DEF-1:0]          clock_ms;
  logic signed [SAMPLE_WIDTH_DEF-1:0] cur_off;
  logic signed [SAMPLE_WIDTH_DEF-1:0] cur_trig;

  // Hand-written walk with the reset register values (trigger 800, debounce
  // 20, gap 30, stall 2000, end 150, release 5000).
  logic signed [SAMPLE_WIDTH_DEF-1:0] dir_shunt [N_DIRECTED] = '{
    -16'sd32768, 16'sd32767, 16'sd801, 16'sd800,          // idle run, cut at threshold
    16'sd1000, 16'sd1000,                                 // debounce across time wrap
    16'sd0, 16'sd1000, 16'sd0, 16'sd1000, 16'sd1000,      // short gap, then repeat pulse
    16'sd1000, 16'sd1000, 16'sd1000,                      // stall, then release timeout
    16'sd1000, 16'sd1000,                                 // fire again
    -16'sd32768, -16'sd32768, -16'sd32768,                // low run ends firing
    16'sd1000, 16'sd1000, 16'sd1000, 16'sd0               // stall left by a low sample
  };
  logic [TIME_WIDTH_DEF-1:0] dir_time [N_DIRECTED] = '{
    32'd0, 32'd100, 32'd119, 32'd120,
    32'hFFFF_FFF0, 32'd4,
    32'd10, 32'd30, 32'd40, 32'd70, 32'd100,
    32'd2070, 32'd3000, 32'd5070,
    32'd5080, 32'd5100,
    32'd5110, 32'd5259, 32'd5260,
    32'd6000, 32'd6020, 32'd8020, 32'd8021
  };

  motor_current_fire_stall_detector_unit uut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (cfg)
  );

  mcfsd_checker chk (
    .clk     (clk),
    .rst     (rst),
    .smp     (smp),
    .res     (res),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random ready, plus one long hold-off on request. The sample
  // side keeps offering while held, so the two internal stages fill and the
  // block drops sample.ready.
  initial begin
    res.ready = 1'b0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res.ready <= ($urandom_range(99) >= sink_gap_pct);
    end
  end

  // Sample value on the requested side of the trigger. A quarter of the picks
  // sit right at the boundary. If that side cannot be reached with the current
  // offset and trigger, any value goes.
  function automatic logic signed [SAMPLE_WIDTH_DEF-1:0] pick_level(input bit hot);
    int t;
    int lo;
    int hi;
    t = int'(cur_trig) + int'(cur_off);
    if (hot) begin
      lo = t + 1;
      hi = 32767;
    end else begin
      lo = -32768;
      hi = t;
    end
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    if (lo > hi) return 16'($urandom);
    if ($urandom_range(3) == 0) return hot ? 16'(lo) : 16'(hi);
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // Offer one item and wait for it to be taken. Valid stays high into the
  // next item unless a random gap is inserted.
  task automatic send(input logic signed [SAMPLE_WIDTH_DEF-1:0] s,
                      input logic [TIME_WIDTH_DEF-1:0] t);
    if (src_gap_pct > 0 && $urandom_range(99) < src_gap_pct) begin
      smp.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
    end
    smp.valid        <= 1'b1;
    smp.shunt_sample <= s;
    smp.now_ms       <= t;
    do @(posedge clk); while (smp.ready !== 1'b1);
  endtask

  // Stop offering and wait until every outstanding result item has arrived.
  task automatic drain();
    smp.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (cfg.ready !== 1'b1);
  endtask

  // Full register set; upper data bits are random and must be ignored.
  // Ends with a write to the unmapped index.
  task automatic configure(input logic signed [SAMPLE_WIDTH_DEF-1:0] off,
                           input logic signed [SAMPLE_WIDTH_DEF-1:0] trig,
                           input logic [THR_WIDTH-1:0] deb,
                           input logic [THR_WIDTH-1:0] gap,
                           input logic [THR_WIDTH-1:0] stl,
                           input logic [THR_WIDTH-1:0] fin,
                           input logic [THR_WIDTH-1:0] rel);
    write_reg(REG_IDLE_OFFSET,        {16'($urandom), off});
    write_reg(REG_TRIGGER_LEVEL,      {16'($urandom), trig});
    write_reg(REG_DEBOUNCE_TIME,      {16'($urandom), deb});
    write_reg(REG_PULSE_GAP_TIME,     {16'($urandom), gap});
    write_reg(REG_STALL_TIME,         {16'($urandom), stl});
    write_reg(REG_END_TIME,           {16'($urandom), fin});
    write_reg(REG_STALL_RELEASE_TIME, {16'($urandom), rel});
    write_reg(REG_UNMAPPED,           $urandom);
    cfg.valid <= 1'b0;
    cur_off  = off;
    cur_trig = trig;
  endtask

  // Short timings so that random runs cross every threshold.
  task automatic configure_short(input logic signed [SAMPLE_WIDTH_DEF-1:0] off,
                                 input logic signed [SAMPLE_WIDTH_DEF-1:0] trig);
    configure(off, trig, 16'($urandom_range(8)), 16'($urandom_range(8)),
              16'($urandom_range(40, 8)), 16'($urandom_range(15, 2)),
              16'($urandom_range(80, 10)));
  endtask

  // Mostly clean high/low runs with small time steps; the rest is noise:
  // arbitrary samples, sometimes with a jump to an arbitrary timestamp.
  task automatic run_phase(input int n_items, input int step_max);
    int sent;
    int len;
    bit hot;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        if ($urandom_range(2) == 0) clock_ms = $urandom;
        send(16'($urandom), clock_ms);
        sent++;
      end else begin
        hot = 1'($urandom_range(1));
        len = ($urandom_range(3) == 0) ? $urandom_range(40, 10) : $urandom_range(8, 1);
        repeat (len) begin
          clock_ms += $urandom_range(step_max);
          send(pick_level(hot), clock_ms);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int step;
    smp.valid        = 1'b0;
    smp.shunt_sample = '0;
    smp.now_ms       = '0;
    cfg.valid        = 1'b0;
    cfg.index        = REG_IDLE_OFFSET;
    cfg.data         = '0;
    rst              = 1'b1;
    hold_req         = 1'b0;
    src_gap_pct      = 17;
    sink_gap_pct     = 64;
    cur_off          = SAMPLE_WIDTH_DEF'(IDLE_OFFSET_RST);
    cur_trig         = SAMPLE_WIDTH_DEF'(TRIGGER_LEVEL_RST);
    clock_ms         = $urandom;
    step             = 6;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Unmapped write first: the walk below relies on the reset values.
    write_reg(REG_UNMAPPED, $urandom);
    cfg.valid <= 1'b0;
    for (int i = 0; i < N_DIRECTED; i++) send(dir_shunt[i], dir_time[i]);

    for (int p = 0; p < 10; p++) begin
      // Load schedule: sample side light/result side heavy, then swapped,
      // then both sides always ready.
      if (p == 3) begin
        src_gap_pct  = 64;
        sink_gap_pct = 17;
      end else if (p == 6) begin
        src_gap_pct  = 0;
        sink_gap_pct = 0;
      end
      if (p > 0) drain();
      case (p)
        0: step = 6;
        2: begin
          // Zero timings, threshold landing on sample 0.
          configure(-16'sd32768, 16'sd32767, '0, '0, '0, '0, '0);
          step = 3;
        end
        4: begin
          // Longest timings, big steps, timestamps wrapping early.
          configure(16'sd32767, -16'sd32768, '1, '1, '1, '1, '1);
          step     = 20000;
          clock_ms = 32'hFFFF_0000;
        end
        5: begin
          configure_short(-16'sd32768, -16'sd32768);  // every sample high
          step = 4;
        end
        6: begin
          configure_short(16'sd32767, 16'sd32767);    // no sample can be high
          step = 4;
        end
        8: begin
          configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom));
          step = 10000;
        end
        default: begin
          configure_short(16'(int'($urandom_range(4000)) - 2000),
                          16'(int'($urandom_range(4000)) - 2000));
          step = 4;
        end
      endcase
      if (p == 7) hold_req = ~hold_req;
      if (p == 4) begin
        // Mid-phase pause until the block has handed back everything.
        run_phase(70, step);
        drain();
        run_phase(75, step);
      end else begin
        run_phase(145, step);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
